>>> rtl/core/lock_queue_manager_revoke_retry_core_defines.svh
// Assertion macros for the lock queue manager checker.
// No dependencies; included by the checker file.
`ifndef LOCK_QUEUE_MANAGER_REVOKE_RETRY_CORE_DEFINES_SVH
`define LOCK_QUEUE_MANAGER_REVOKE_RETRY_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LQM_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lqm: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define LQM_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lqm: next-cycle check failed");

`endif

>>> rtl/core/lqm_pkg.sv
// Shared types and codes of the lock queue manager.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package lqm_pkg;

  localparam logic KIND_ACQUIRE = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  localparam logic [1:0] MSG_REPLY  = 2'd0;
  localparam logic [1:0] MSG_REVOKE = 2'd1;
  localparam logic [1:0] MSG_RETRY  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RETRY = 2'd1;
  localparam logic [1:0] ST_IOERR = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic [1:0] msg_type;
    logic [1:0] reply_status;
    logic [3:0] dest_client;
    logic [5:0] msg_lock;
    logic       last;
  } res_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic read;
    logic decide;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic emit_last;
    logic out_free;
  } dp_stat_t;

  function automatic res_t make_item(logic [1:0] mtype, logic [1:0] status,
                                     logic [3:0] dest, logic [5:0] lock,
                                     logic fin);
    res_t r;
    r.msg_type     = mtype;
    r.reply_status = status;
    r.dest_client  = dest;
    r.msg_lock     = lock;
    r.last         = fin;
    return r;
  endfunction

endpackage

>>> rtl/core/lqm_ctrl.sv
// Sequencer of the lock queue manager: clear pass, request read, decide, emit.
// Depends on lqm_pkg; drives the datapath lqm_dpath by commands.
`timescale 1ns / 1ps

module lqm_ctrl import lqm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    CLEAR,
    IDLE,
    READ,
    DECIDE,
    EMIT
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= CLEAR;
      s_tready <= 1'b0;
    end else begin
      case (state)
        CLEAR: begin
          if (stat.clear_done) begin
            state    <= IDLE;
            s_tready <= 1'b1;
          end
        end
        IDLE: begin
          if (s_tvalid && s_tready) begin
            state    <= READ;
            s_tready <= 1'b0;
          end
        end
        READ:   state <= DECIDE;
        DECIDE: state <= EMIT;
        EMIT: begin
          if (stat.out_free && stat.emit_last) begin
            state    <= IDLE;
            s_tready <= 1'b1;
          end
        end
        default: begin
          state    <= CLEAR;
          s_tready <= 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    cmd.clear  = (state == CLEAR);
    cmd.load   = (state == IDLE) && s_tvalid && s_tready;
    cmd.read   = (state == READ);
    cmd.decide = (state == DECIDE);
    cmd.emit   = (state == EMIT) && stat.out_free;
  end

endmodule

>>> rtl/core/lqm_dpath.sv
// Datapath of the lock queue manager: queue memories, decision logic, output register.
// Depends on lqm_pkg; commanded by lqm_ctrl.
`timescale 1ns / 1ps

module lqm_dpath import lqm_pkg::*; #(
  parameter int LOCK_COUNT   = 64,
  parameter int QUEUE_DEPTH  = 8,
  parameter int CLIENT_COUNT = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  input  logic        in_kind,
  input  logic [5:0]  in_lock,
  input  logic [3:0]  in_client,
  input  logic        in_reach,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,
  output logic [1:0]  m_tuser,
  output logic        m_tlast
);

  localparam int HEAD_W     = $clog2(QUEUE_DEPTH);
  localparam int COUNT_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int LOCK_AW    = (LOCK_COUNT > 1) ? $clog2(LOCK_COUNT) : 1;
  localparam int META_W     = HEAD_W + COUNT_W;
  localparam int WAIT_DEPTH = LOCK_COUNT * (2 ** HEAD_W);

  logic [META_W-1:0] meta_mem [0:LOCK_COUNT-1];
  logic [3:0]        waiter_mem [0:WAIT_DEPTH-1];

  logic              req_kind;
  logic [5:0]        req_lock;
  logic [3:0]        req_client;
  logic              req_reach;
  logic [META_W-1:0] meta_rd;
  logic [3:0]        waiter_head_rd;
  logic [3:0]        waiter_next_rd;
  logic [LOCK_AW-1:0] clr_addr;
  res_t              res [3];
  logic [1:0]        res_num;
  logic [1:0]        emit_idx;

  logic [LOCK_AW-1:0] lock_addr;
  logic [HEAD_W-1:0]  head_rd;
  logic [COUNT_W-1:0] cnt_rd;
  logic [HEAD_W-1:0]  head_inc;
  logic [HEAD_W:0]    tail_sum;
  logic [HEAD_W-1:0]  tail_pos;
  logic               lock_ok;
  logic               client_ok;
  res_t               dec_item [3];
  logic [1:0]         dec_num;
  logic               dec_wr_waiter;
  logic               dec_wr_meta;
  logic [META_W-1:0]  dec_meta;
  res_t               cur;

  assign lock_addr = LOCK_AW'(req_lock);
  assign head_rd   = meta_rd[HEAD_W-1:0];
  assign cnt_rd    = meta_rd[META_W-1:HEAD_W];
  assign head_inc  = (head_rd == HEAD_W'(QUEUE_DEPTH - 1)) ? '0 : head_rd + HEAD_W'(1);
  assign tail_sum  = (HEAD_W + 1)'(head_rd) + (HEAD_W + 1)'(cnt_rd);
  assign tail_pos  = (tail_sum >= (HEAD_W + 1)'(QUEUE_DEPTH))
                   ? HEAD_W'(tail_sum - (HEAD_W + 1)'(QUEUE_DEPTH))
                   : HEAD_W'(tail_sum);
  assign lock_ok   = (32'(req_lock) < LOCK_COUNT);
  assign client_ok = req_reach && (32'(req_client) < CLIENT_COUNT);

  always_comb begin
    dec_item[0]   = make_item(MSG_REPLY, ST_IOERR, req_client, req_lock, 1'b1);
    dec_item[1]   = make_item(MSG_REPLY, ST_OK, req_client, req_lock, 1'b1);
    dec_item[2]   = make_item(MSG_REPLY, ST_OK, req_client, req_lock, 1'b1);
    dec_num       = 2'd1;
    dec_wr_waiter = 1'b0;
    dec_wr_meta   = 1'b0;
    dec_meta      = meta_rd;
    if (lock_ok) begin
      if (req_kind == KIND_ACQUIRE) begin
        if (!client_ok) begin
          dec_item[0] = make_item(MSG_REPLY, ST_IOERR, req_client, req_lock, 1'b1);
        end else if (cnt_rd == COUNT_W'(QUEUE_DEPTH)) begin
          dec_item[0] = make_item(MSG_REPLY, ST_FULL, req_client, req_lock, 1'b1);
        end else begin
          dec_wr_waiter = 1'b1;
          dec_wr_meta   = 1'b1;
          dec_meta      = {cnt_rd + COUNT_W'(1), head_rd};
          if (cnt_rd == '0) begin
            dec_item[0] = make_item(MSG_REPLY, ST_OK, req_client, req_lock, 1'b1);
          end else if (cnt_rd == COUNT_W'(1)) begin
            dec_item[0] = make_item(MSG_REVOKE, ST_OK, waiter_head_rd, req_lock, 1'b0);
            dec_item[1] = make_item(MSG_REPLY, ST_RETRY, req_client, req_lock, 1'b1);
            dec_num     = 2'd2;
          end else begin
            dec_item[0] = make_item(MSG_REPLY, ST_RETRY, req_client, req_lock, 1'b1);
          end
        end
      end else begin
        if (!client_ok) begin
          dec_item[0] = make_item(MSG_REPLY, ST_OK, req_client, req_lock, 1'b1);
        end else if (cnt_rd == '0 || waiter_head_rd != req_client) begin
          dec_item[0] = make_item(MSG_REPLY, ST_IOERR, req_client, req_lock, 1'b1);
        end else begin
          dec_wr_meta = 1'b1;
          dec_meta    = {cnt_rd - COUNT_W'(1), head_inc};
          if (cnt_rd == COUNT_W'(1)) begin
            dec_item[0] = make_item(MSG_REPLY, ST_OK, req_client, req_lock, 1'b1);
          end else if (cnt_rd == COUNT_W'(2)) begin
            dec_item[0] = make_item(MSG_RETRY, ST_OK, waiter_next_rd, req_lock, 1'b0);
            dec_num     = 2'd2;
          end else begin
            dec_item[0] = make_item(MSG_RETRY, ST_OK, waiter_next_rd, req_lock, 1'b0);
            dec_item[1] = make_item(MSG_REVOKE, ST_OK, waiter_next_rd, req_lock, 1'b0);
            dec_num     = 2'd3;
          end
        end
      end
    end
  end

  // queue memories
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      meta_mem[clr_addr] <= '0;
    end else if (cmd.decide && dec_wr_meta) begin
      meta_mem[lock_addr] <= dec_meta;
    end
    if (cmd.load) begin
      meta_rd <= meta_mem[LOCK_AW'(in_lock)];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide && dec_wr_waiter) begin
      waiter_mem[{lock_addr, tail_pos}] <= req_client;
    end
    if (cmd.read) begin
      waiter_head_rd <= waiter_mem[{lock_addr, head_rd}];
      waiter_next_rd <= waiter_mem[{lock_addr, head_inc}];
    end
  end

  // request and result registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_kind   <= in_kind;
      req_lock   <= in_lock;
      req_client <= in_client;
      req_reach  <= in_reach;
    end
    if (cmd.decide) begin
      res[0]  <= dec_item[0];
      res[1]  <= dec_item[1];
      res[2]  <= dec_item[2];
      res_num <= dec_num;
    end
  end

  assign cur = res[emit_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      emit_idx <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.clear && !stat.clear_done) begin
        clr_addr <= clr_addr + LOCK_AW'(1);
      end
      if (cmd.decide) begin
        emit_idx <= '0;
      end else if (cmd.emit) begin
        emit_idx <= emit_idx + 2'd1;
      end
      if (cmd.emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= {4'b0, cur.msg_lock, cur.dest_client, cur.reply_status};
      m_tuser <= cur.msg_type;
      m_tlast <= cur.last;
    end
  end

  always_comb begin
    stat.clear_done = (clr_addr == LOCK_AW'(LOCK_COUNT - 1));
    stat.emit_last  = (emit_idx == res_num - 2'd1);
    stat.out_free   = !m_tvalid || m_tready;
  end

endmodule

>>> rtl/core/lock_queue_manager_revoke_retry_core.sv
// Top level of the queued lock manager with revoke and retry messages.
// Depends on lqm_pkg, lqm_ctrl and lqm_dpath.
//
//   Port group | Dir | tdata (low bit up)                                  | tuser    | tlast
//   s_*        | in  | lock_index[5:0] client_num[9:6] client_reachable[10] | kind     | -
//   m_*        | out | reply_status[1:0] dest_client[5:2] msg_lock[11:6]    | msg_type | last
//
// A request passes through accept and queue state read, waiter reads, decide and
// write back, then an emit step per result, 1 to 3 results; s_tready stays low
// until the last result is emitted. The queue state memory has a single update per request.
// After reset a clearing pass zeroes every queue state entry; s_tready
// stays low until it ends. A stalled output holds the block in its emit step.
`timescale 1ns / 1ps

module lock_queue_manager_revoke_retry_core import lqm_pkg::*; #(
  parameter int LOCK_COUNT   = 64,
  parameter int QUEUE_DEPTH  = 8,
  parameter int CLIENT_COUNT = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,  // lock_index, client_num, client_reachable, zero fill
  input  logic        s_tuser,  // kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,  // reply_status, dest_client, msg_lock, zero fill
  output logic [1:0]  m_tuser,  // msg_type
  output logic        m_tlast
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  lqm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lqm_dpath #(
    .LOCK_COUNT   (LOCK_COUNT),
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .CLIENT_COUNT (CLIENT_COUNT)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_kind   (s_tuser),
    .in_lock   (s_tdata[5:0]),
    .in_client (s_tdata[9:6]),
    .in_reach  (s_tdata[10]),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

>>> rtl/core/lqm_checker.sv
// Port-level checks of the lock queue manager, bound to the top level.
// Depends on lqm_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "lock_queue_manager_revoke_retry_core_defines.svh"

module lqm_checker import lqm_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic [1:0]  m_tuser,
  input logic        m_tlast
);

  logic [18:0] out_word;

  assign out_word = {m_tlast, m_tuser, m_tdata};

  // one request at a time
  `LQM_ASSERT_NXT(a_one_req, clk, rst, s_tvalid && s_tready, !s_tready)
  // only the reply closes a request
  `LQM_ASSERT_IMP(a_last_reply, clk, rst, m_tvalid, m_tlast == (m_tuser == MSG_REPLY))
  // messages carry no status
  `LQM_ASSERT_IMP(a_msg_status, clk, rst, m_tvalid && m_tuser != MSG_REPLY, m_tdata[1:0] == ST_OK)
  // hold a stalled transfer
  `LQM_ASSERT_NXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(out_word))

endmodule

bind lock_queue_manager_revoke_retry_core lqm_checker u_lqm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
